@@ src/tiny_vm_instruction_execute_unit_defines.svh @@
// Assertion macros shared by the execute unit.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef TINY_VM_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
`define TINY_VM_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TVM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TVM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tvm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tvm_pkg;

  // Fixed geometry of the machine.
  localparam int unsigned NumRegs  = 16;
  localparam int unsigned RegIdxW  = $clog2(NumRegs);
  localparam int unsigned MemBytes = 256;
  localparam int unsigned MemAddrW = $clog2(MemBytes);
  localparam int unsigned ImmW     = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CmdW     = 5;

  // Instruction codes as they arrive on the input channel.
  typedef enum logic [CmdW-1:0] {
    CMD_READ = 5'd0,
    CMD_WRITE = 5'd1,
    CMD_SET = 5'd2,
    CMD_ADD = 5'd3,
    CMD_ADDI = 5'd4,
    CMD_SUB = 5'd5,
    CMD_SUBI = 5'd6,
    CMD_SHL = 5'd7,
    CMD_SHR = 5'd8,
    CMD_ANDI = 5'd9,
    CMD_ORI = 5'd10,
    CMD_XORI = 5'd11,
    CMD_AND = 5'd12,
    CMD_OR = 5'd13,
    CMD_XOR = 5'd14,
    CMD_STR = 5'd15,
    CMD_LDR = 5'd16,
    CMD_ST = 5'd17,
    CMD_LD = 5'd18,
    CMD_JMP = 5'd19,
    CMD_JZ = 5'd20,
    CMD_JNZ = 5'd21,
    CMD_HLT = 5'd22
  } cmd_e;

  // Operation classes carried out by the back end.
  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_PASS  = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_AND   = 4'd4,
    OP_OR    = 4'd5,
    OP_XOR   = 4'd6,
    OP_SHL   = 4'd7,
    OP_SHR   = 4'd8,
    OP_STORE = 4'd9,
    OP_LOAD  = 4'd10,
    OP_OUT   = 4'd11,
    OP_JMP   = 4'd12,
    OP_JZ    = 4'd13,
    OP_JNZ   = 4'd14,
    OP_HALT  = 4'd15
  } exop_e;

  // One micro-operation as it travels through the queue.
  typedef struct packed {
    exop_e              op;
    logic               use_imm;
    logic [RegIdxW-1:0] idx_a;
    logic [RegIdxW-1:0] idx_b;
    logic               wr_en;
    logic [RegIdxW-1:0] wr_idx;
    logic [ImmW-1:0]    imm;
    logic               last;
  } uop_t;

  // Result word handed to the output channel.
  typedef struct packed {
    logic [ByteW-1:0] write_byte;
    logic             write_valid;
    logic             branch_taken;
    logic [ImmW-1:0]  branch_target;
    logic             halted;
  } res_t;

endpackage

`default_nettype wire

@@ src/tvm_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one decoded instruction per word.
interface tvm_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] command;
  logic [3:0] dest_reg;
  logic [3:0] src_reg_a;
  logic [3:0] src_reg_b;
  logic [15:0] immediate;
  logic [7:0] read_byte;
  logic       io_ok;

  modport source (
    output valid, command, dest_reg, src_reg_a, src_reg_b, immediate, read_byte, io_ok,
    input  ready
  );
  modport sink (
    input  valid, command, dest_reg, src_reg_a, src_reg_b, immediate, read_byte, io_ok,
    output ready
  );
endinterface

// Output channel: one result per instruction.
interface tvm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  write_byte;
  logic        write_valid;
  logic        branch_taken;
  logic [15:0] branch_target;
  logic        halted;

  modport source (
    output valid, write_byte, write_valid, branch_taken, branch_target, halted,
    input  ready
  );
  modport sink (
    input  valid, write_byte, write_valid, branch_taken, branch_target, halted,
    output ready
  );
endinterface

`default_nettype wire

@@ src/tvm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tvm_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  tvm_in_if.sink             in_i,
  input  wire logic          space_i,
  output logic               push_o,
  output tvm_pkg::uop_t      push_uop_o
);
  import tvm_pkg::*;

  uop_t dec_uop;
  uop_t status_uop;
  logic need_split;
  logic accept;
  logic split_q;
  logic split_d;
  uop_t held_uop_q;

  // Decode the incoming word into the micro-operation that finishes it.
  always_comb begin
    dec_uop         = '0;
    dec_uop.op      = OP_NOP;
    dec_uop.idx_a   = in_i.src_reg_a;
    dec_uop.idx_b   = in_i.src_reg_b;
    dec_uop.wr_idx  = in_i.dest_reg;
    dec_uop.imm     = in_i.immediate;
    dec_uop.last    = 1'b1;
    need_split      = 1'b0;
    case (cmd_e'(in_i.command))
      CMD_READ: begin
        dec_uop.op      = OP_PASS;
        dec_uop.use_imm = 1'b1;
        dec_uop.imm     = ImmW'(in_i.read_byte);
        dec_uop.wr_en   = 1'b1;
        // The status goes first unless the byte overwrites it anyway.
        need_split      = (in_i.src_reg_a != in_i.dest_reg);
      end
      CMD_WRITE: begin
        dec_uop.op     = OP_OUT;
        dec_uop.idx_b  = in_i.dest_reg;
        dec_uop.imm    = ImmW'(in_i.io_ok);
        dec_uop.wr_en  = 1'b1;
        dec_uop.wr_idx = in_i.src_reg_a;
      end
      CMD_SET: begin
        dec_uop.op      = OP_PASS;
        dec_uop.use_imm = 1'b1;
        dec_uop.wr_en   = 1'b1;
      end
      CMD_ADD: begin
        dec_uop.op    = OP_ADD;
        dec_uop.wr_en = 1'b1;
      end
      CMD_ADDI: begin
        dec_uop.op      = OP_ADD;
        dec_uop.use_imm = 1'b1;
        dec_uop.wr_en   = 1'b1;
      end
      CMD_SUB: begin
        dec_uop.op    = OP_SUB;
        dec_uop.wr_en = 1'b1;
      end
      CMD_SUBI: begin
        dec_uop.op      = OP_SUB;
        dec_uop.use_imm = 1'b1;
        dec_uop.wr_en   = 1'b1;
      end
      CMD_SHL: begin
        dec_uop.op    = OP_SHL;
        dec_uop.wr_en = 1'b1;
      end
      CMD_SHR: begin
        dec_uop.op    = OP_SHR;
        dec_uop.wr_en = 1'b1;
      end
      CMD_ANDI: begin
        dec_uop.op      = OP_AND;
        dec_uop.use_imm = 1'b1;
        dec_uop.wr_en   = 1'b1;
      end
      CMD_ORI: begin
        dec_uop.op      = OP_OR;
        dec_uop.use_imm = 1'b1;
        dec_uop.wr_en   = 1'b1;
      end
      CMD_XORI: begin
        dec_uop.op      = OP_XOR;
        dec_uop.use_imm = 1'b1;
        dec_uop.wr_en   = 1'b1;
      end
      CMD_AND: begin
        dec_uop.op    = OP_AND;
        dec_uop.wr_en = 1'b1;
      end
      CMD_OR: begin
        dec_uop.op    = OP_OR;
        dec_uop.wr_en = 1'b1;
      end
      CMD_XOR: begin
        dec_uop.op    = OP_XOR;
        dec_uop.wr_en = 1'b1;
      end
      CMD_STR: begin
        dec_uop.op    = OP_STORE;
        dec_uop.idx_b = in_i.dest_reg;
      end
      CMD_LDR: begin
        dec_uop.op    = OP_LOAD;
        dec_uop.wr_en = 1'b1;
      end
      CMD_ST: begin
        dec_uop.op      = OP_STORE;
        dec_uop.use_imm = 1'b1;
      end
      CMD_LD: begin
        dec_uop.op     = OP_LOAD;
        dec_uop.wr_en  = 1'b1;
        dec_uop.wr_idx = in_i.immediate[RegIdxW-1:0];
      end
      CMD_JMP: begin
        dec_uop.op = OP_JMP;
      end
      CMD_JZ: begin
        dec_uop.op    = OP_JZ;
        dec_uop.idx_b = in_i.dest_reg;
      end
      CMD_JNZ: begin
        dec_uop.op    = OP_JNZ;
        dec_uop.idx_b = in_i.dest_reg;
      end
      CMD_HLT: begin
        dec_uop.op = OP_HALT;
      end
      default: begin
        dec_uop.op = OP_NOP;
      end
    endcase
  end

  // Status write of a read, issued ahead of the byte write and silent on output.
  always_comb begin
    status_uop         = dec_uop;
    status_uop.op      = OP_PASS;
    status_uop.use_imm = 1'b1;
    status_uop.imm     = ImmW'(in_i.io_ok);
    status_uop.wr_en   = 1'b1;
    status_uop.wr_idx  = in_i.src_reg_a;
    status_uop.last    = 1'b0;
  end

  // Input is held off while the second half of a split read is queued.
  assign in_i.ready = space_i && !split_q;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    split_d = split_q;
    if (split_q && space_i) begin
      split_d = 1'b0;
    end else if (accept && need_split) begin
      split_d = 1'b1;
    end
  end

  assign push_o = split_q ? space_i : accept;

  always_comb begin
    if (split_q) begin
      push_uop_o = held_uop_q;
    end else if (need_split) begin
      push_uop_o = status_uop;
    end else begin
      push_uop_o = dec_uop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q <= 1'b0;
    end else begin
      split_q <= split_d;
    end
  end

  // The byte write waits here while the status write goes ahead.
  always_ff @(posedge clk_i) begin
    if (accept && need_split) begin
      held_uop_q <= dec_uop;
    end
  end

endmodule

`default_nettype wire

@@ src/tvm_uop_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "tiny_vm_instruction_execute_unit_defines.svh"

module tvm_uop_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tvm_pkg::uop_t  push_uop_i,
  output logic                space_o,
  input  wire logic           pop_i,
  output logic                head_valid_o,
  output tvm_pkg::uop_t       head_uop_o
);
  import tvm_pkg::*;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  uop_t              q_mem [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q;
  logic [QPtrW-1:0]  rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;

  assign space_o      = (cnt_q != QCntW'(QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_uop_o   = q_mem[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_ptr_q] <= push_uop_i;
    end
  end

  `TVM_ASSERT_IMP(a_push_has_room, push_i, space_o, "queue pushed while full")
  `TVM_ASSERT_IMP(a_pop_has_entry, pop_i, head_valid_o, "queue popped while empty")

endmodule

`default_nettype wire

@@ src/tvm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "tiny_vm_instruction_execute_unit_defines.svh"

module tvm_back #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           head_valid_i,
  input  wire tvm_pkg::uop_t  head_uop_i,
  output logic                pop_o,
  tvm_out_if.source           out_o
);
  import tvm_pkg::*;

  logic advance;

  // Register file with write-first read ports.
  logic [WORD_WIDTH-1:0] rf_mem [NumRegs];
  logic [NumRegs-1:0]    rf_vld_q;
  logic                  rf_we;
  logic [RegIdxW-1:0]    rf_waddr;
  logic [WORD_WIDTH-1:0] rf_wdata;
  logic [WORD_WIDTH-1:0] rda_q;
  logic [WORD_WIDTH-1:0] rdb_q;

  // Data memory.
  logic [ByteW-1:0]      dmem [MemBytes];
  logic [MemBytes-1:0]   dmem_vld_q;
  logic [MemAddrW-1:0]   dmem_addr;
  logic                  dmem_we;
  logic [ByteW-1:0]      dmem_rdata_q;

  // Execute stage.
  logic                  ex_vld_q;
  uop_t                  ex_uop_q;
  logic                  fwd_a;
  logic                  fwd_b;
  logic [WORD_WIDTH-1:0] opa;
  logic [WORD_WIDTH-1:0] reg_b;
  logic [WORD_WIDTH-1:0] opb;
  logic                  shift_big;
  logic [WORD_WIDTH-1:0] alu_res;
  res_t                  ex_res;

  // Memory and write-back stage.
  logic                  mem_vld_q;
  uop_t                  mem_uop_q;
  logic [WORD_WIDTH-1:0] mem_alu_q;
  res_t                  mem_res_q;

  // Output register.
  logic                  out_vld_q;
  res_t                  out_res_q;

  // The whole pipeline moves together unless a result waits at the output.
  assign advance = !out_vld_q || out_o.ready;
  assign pop_o   = advance && head_valid_i;

  // Write-back from the memory stage.
  assign rf_we    = advance && mem_vld_q && mem_uop_q.wr_en;
  assign rf_waddr = mem_uop_q.wr_idx;
  assign rf_wdata = (mem_uop_q.op == OP_LOAD) ? WORD_WIDTH'(dmem_rdata_q) : mem_alu_q;

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    if (advance) begin
      if (rf_we && (rf_waddr == head_uop_i.idx_a)) begin
        rda_q <= rf_wdata;
      end else begin
        rda_q <= rf_vld_q[head_uop_i.idx_a] ? rf_mem[head_uop_i.idx_a] : '0;
      end
      if (rf_we && (rf_waddr == head_uop_i.idx_b)) begin
        rdb_q <= rf_wdata;
      end else begin
        rdb_q <= rf_vld_q[head_uop_i.idx_b] ? rf_mem[head_uop_i.idx_b] : '0;
      end
    end
  end

  // Entries that were never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (rf_we) begin
      rf_vld_q[rf_waddr] <= 1'b1;
    end
  end

  // Operands, with the memory stage result forwarded ahead of its write-back.
  assign fwd_a = mem_vld_q && mem_uop_q.wr_en && (mem_uop_q.wr_idx == ex_uop_q.idx_a);
  assign fwd_b = mem_vld_q && mem_uop_q.wr_en && (mem_uop_q.wr_idx == ex_uop_q.idx_b);
  assign opa   = fwd_a ? rf_wdata : rda_q;
  assign reg_b = fwd_b ? rf_wdata : rdb_q;
  assign opb   = ex_uop_q.use_imm ? WORD_WIDTH'(ex_uop_q.imm) : reg_b;

  assign shift_big = (ex_uop_q.imm >= ImmW'(WORD_WIDTH));

  // Arithmetic and logic.
  always_comb begin
    case (ex_uop_q.op)
      OP_PASS: alu_res = opb;
      OP_ADD:  alu_res = opa + opb;
      OP_SUB:  alu_res = opa - opb;
      OP_AND:  alu_res = opa & opb;
      OP_OR:   alu_res = opa | opb;
      OP_XOR:  alu_res = opa ^ opb;
      OP_SHL:  alu_res = shift_big ? '0 : (opa << ex_uop_q.imm);
      OP_SHR:  alu_res = shift_big ? '0 : (opa >> ex_uop_q.imm);
      OP_OUT:  alu_res = WORD_WIDTH'(ex_uop_q.imm);
      default: alu_res = '0;
    endcase
  end

  // Output word: character, branch and halt reporting.
  always_comb begin
    ex_res = '0;
    case (ex_uop_q.op)
      OP_OUT: begin
        ex_res.write_byte  = reg_b[ByteW-1:0];
        ex_res.write_valid = 1'b1;
      end
      OP_JMP:  ex_res.branch_taken = 1'b1;
      OP_JZ:   ex_res.branch_taken = (reg_b == '0);
      OP_JNZ:  ex_res.branch_taken = (reg_b != '0);
      OP_HALT: ex_res.halted = 1'b1;
      default: ex_res = '0;
    endcase
    ex_res.branch_target = ex_res.branch_taken ? ex_uop_q.imm : '0;
  end

  // Byte memory: stores write at the end of execute, loads read into a register.
  assign dmem_addr = opa[MemAddrW-1:0];
  assign dmem_we   = advance && ex_vld_q && (ex_uop_q.op == OP_STORE);

  always_ff @(posedge clk_i) begin
    if (dmem_we) begin
      dmem[dmem_addr] <= opb[ByteW-1:0];
    end
    if (advance) begin
      dmem_rdata_q <= dmem_vld_q[dmem_addr] ? dmem[dmem_addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmem_vld_q <= '0;
    end else if (dmem_we) begin
      dmem_vld_q[dmem_addr] <= 1'b1;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q  <= 1'b0;
      mem_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      ex_vld_q  <= head_valid_i;
      mem_vld_q <= ex_vld_q;
      out_vld_q <= mem_vld_q && mem_uop_q.last;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ex_uop_q  <= head_uop_i;
      mem_uop_q <= ex_uop_q;
      mem_alu_q <= alu_res;
      mem_res_q <= ex_res;
      out_res_q <= mem_res_q;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.write_byte    = out_res_q.write_byte;
  assign out_o.write_valid   = out_res_q.write_valid;
  assign out_o.branch_taken  = out_res_q.branch_taken;
  assign out_o.branch_target = out_res_q.branch_target;
  assign out_o.halted        = out_res_q.halted;

  `TVM_ASSERT_NXT(a_ex_holds_on_stall, !advance && ex_vld_q, ex_vld_q && $stable(ex_uop_q), "execute stage changed during a stall")
  `TVM_ASSERT_NXT(a_status_write_silent, advance && mem_vld_q && !mem_uop_q.last, !out_vld_q, "status write produced a result")

endmodule

`default_nettype wire

@@ src/tiny_vm_instruction_execute_unit.sv @@
// Channel   Direction  Handshake      Word
// in_i      sink       valid / ready  command, register indices, immediate, read byte, io status
// out_o     source     valid / ready  written byte and flag, branch flag and target, halt flag
//
// One instruction is accepted per cycle while the queue has room and no split read is pending;
// a read whose status and byte registers differ needs two register-file writes, so it is split
// in two and input is held off until the byte write is queued. A result passes through the
// queue, the execute and memory stages and the output register on its way out.
// Reset clears the register file and data memory at once through per-entry valid bits.
// A result held at the output stalls the back end; the two-entry queue lets the front keep going.
`timescale 1ns / 1ps
`default_nettype none

module tiny_vm_instruction_execute_unit #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tvm_in_if.sink     in_i,
  tvm_out_if.source  out_o
);
  import tvm_pkg::*;

  logic push;
  uop_t push_uop;
  logic space;
  logic pop;
  logic head_valid;
  uop_t head_uop;

  // Decode and split.
  tvm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .space_i    (space),
    .push_o     (push),
    .push_uop_o (push_uop)
  );

  // Decoupling queue.
  tvm_uop_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_uop_i   (push_uop),
    .space_o      (space),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_uop_o   (head_uop)
  );

  // Register file, byte memory and result pipeline.
  tvm_back #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_uop_i   (head_uop),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

@@ tb/tvm_execute_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the execute unit. It keeps its own copy of the register file
// and the data memory, works out the result word of every accepted instruction and
// compares each accepted result word with the oldest one still outstanding.
module tvm_execute_checker
  import tvm_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  tvm_in_if    in_mon,
  tvm_out_if   out_mon,
  output int   failures_o,
  output int   pending_o
);

  // Shadow machine state and the result words still owed by the unit.
  logic [WORD_WIDTH-1:0] reg_model [NumRegs];
  logic [ByteW-1:0]      mem_model [MemBytes];
  res_t                  expected_results [$];
  int                    results_seen;

  initial begin
    failures_o   = 0;
    pending_o    = 0;
    results_seen = 0;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_failure(input string msg);
    $display("[%0t] result word %0d: %s", $time, results_seen, msg);
    failures_o++;
  endtask

  task automatic compare_field(input string name, input logic [ImmW-1:0] got,
                               input logic [ImmW-1:0] want);
    if (got !== want) begin
      report_failure($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Runs one instruction on the shadow state and returns the result word it produces.
  function automatic res_t execute_instruction(
    input logic [CmdW-1:0]    cmd,
    input logic [RegIdxW-1:0] rd,
    input logic [RegIdxW-1:0] ra,
    input logic [RegIdxW-1:0] rb,
    input logic [ImmW-1:0]    imm,
    input logic [ByteW-1:0]   rbyte,
    input logic               ok
  );
    logic [WORD_WIDTH-1:0] a;
    logic [WORD_WIDTH-1:0] b;
    logic [WORD_WIDTH-1:0] immw;
    logic [MemAddrW-1:0]   addr;
    res_t                  res;
    a    = reg_model[ra];
    b    = reg_model[rb];
    immw = WORD_WIDTH'(imm);
    addr = a[MemAddrW-1:0];
    res  = '0;
    case (cmd)
      CMD_READ: begin
        // The status goes in first, so the byte wins when both indices agree.
        reg_model[ra] = WORD_WIDTH'(ok);
        reg_model[rd] = WORD_WIDTH'(rbyte);
      end
      CMD_WRITE: begin
        res.write_byte  = reg_model[rd][ByteW-1:0];
        res.write_valid = 1'b1;
        reg_model[ra]   = WORD_WIDTH'(ok);
      end
      CMD_SET:  reg_model[rd] = immw;
      CMD_ADD:  reg_model[rd] = a + b;
      CMD_ADDI: reg_model[rd] = a + immw;
      CMD_SUB:  reg_model[rd] = a - b;
      CMD_SUBI: reg_model[rd] = a - immw;
      CMD_SHL:  reg_model[rd] = (imm >= WORD_WIDTH) ? '0 : a << imm;
      CMD_SHR:  reg_model[rd] = (imm >= WORD_WIDTH) ? '0 : a >> imm;
      CMD_ANDI: reg_model[rd] = a & immw;
      CMD_ORI:  reg_model[rd] = a | immw;
      CMD_XORI: reg_model[rd] = a ^ immw;
      CMD_AND:  reg_model[rd] = a & b;
      CMD_OR:   reg_model[rd] = a | b;
      CMD_XOR:  reg_model[rd] = a ^ b;
      CMD_STR:  mem_model[addr] = reg_model[rd][ByteW-1:0];
      CMD_LDR:  reg_model[rd] = WORD_WIDTH'(mem_model[addr]);
      CMD_ST:   mem_model[addr] = imm[ByteW-1:0];
      CMD_LD:   reg_model[imm[RegIdxW-1:0]] = WORD_WIDTH'(mem_model[addr]);
      CMD_JMP:  res.branch_taken = 1'b1;
      CMD_JZ:   res.branch_taken = (reg_model[rd] == '0);
      CMD_JNZ:  res.branch_taken = (reg_model[rd] != '0);
      CMD_HLT:  res.halted = 1'b1;
      default: ;
    endcase
    if (res.branch_taken) begin
      res.branch_target = imm;
    end
    return res;
  endfunction

  // Checks one accepted result word against the oldest outstanding one.
  task automatic check_result();
    res_t want;
    if (expected_results.size() == 0) begin
      report_failure("arrived with no instruction outstanding");
    end else begin
      want = expected_results.pop_front();
      compare_field("write_byte", ImmW'(out_mon.write_byte), ImmW'(want.write_byte));
      compare_field("write_valid", ImmW'(out_mon.write_valid), ImmW'(want.write_valid));
      compare_field("branch_taken", ImmW'(out_mon.branch_taken), ImmW'(want.branch_taken));
      compare_field("branch_target", out_mon.branch_target, want.branch_target);
      compare_field("halted", ImmW'(out_mon.halted), ImmW'(want.halted));
    end
    results_seen++;
  endtask

  // Both channels are sampled at the rising edge, before the driver's updates land.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) reg_model[i] = '0;
      for (int i = 0; i < MemBytes; i++) mem_model[i] = '0;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        check_result();
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_results.push_back(execute_instruction(in_mon.command, in_mon.dest_reg,
            in_mon.src_reg_a, in_mon.src_reg_b, in_mon.immediate, in_mon.read_byte,
            in_mon.io_ok));
      end
    end
    pending_o = expected_results.size();
  end

endmodule

@@ tb/tb_tiny_vm_instruction_execute_unit.sv @@
`timescale 1ns / 1ps

// Drives instruction words into the execute unit with random gaps, takes result words
// with random stalls, and leaves all checking to the checker beside the unit.
module tb_tiny_vm_instruction_execute_unit;
  import tvm_pkg::*;

  localparam int unsigned WordWidth  = 32;
  localparam int          RandomWords = 600;
  localparam int          DrainCycles = 12;
  localparam logic [CmdW-1:0] CmdUnusedLo = 5'd23;
  localparam logic [CmdW-1:0] CmdUnusedHi = 5'd31;

  logic clk_i;
  logic rst_ni;
  int   failures;
  int   pending;
  int   words_sent;
  bit   steady_flow;

  tvm_in_if  instr_ch ();
  tvm_out_if result_ch ();

  tiny_vm_instruction_execute_unit #(
    .WORD_WIDTH(WordWidth)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (instr_ch),
    .out_o (result_ch)
  );

  tvm_execute_checker #(
    .WORD_WIDTH(WordWidth)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (instr_ch),
    .out_mon   (result_ch),
    .failures_o(failures),
    .pending_o (pending)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hard limit on the run, far beyond the slowest correct one.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [RegIdxW-1:0] any_reg();
    return RegIdxW'($urandom_range(0, NumRegs - 1));
  endfunction

  // Sends one instruction word after a random gap and waits until it is taken.
  task automatic send_instruction(
    input logic [CmdW-1:0]    cmd,
    input logic [RegIdxW-1:0] rd,
    input logic [RegIdxW-1:0] ra,
    input logic [RegIdxW-1:0] rb,
    input logic [ImmW-1:0]    imm,
    input logic [ByteW-1:0]   rbyte,
    input logic               ok
  );
    int gap;
    // Now and then both sides run without any idling for a stretch.
    if (words_sent % 48 == 0) begin
      steady_flow = ($urandom_range(0, 3) == 0);
    end
    gap = steady_flow ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      instr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    instr_ch.valid     <= 1'b1;
    instr_ch.command   <= cmd;
    instr_ch.dest_reg  <= rd;
    instr_ch.src_reg_a <= ra;
    instr_ch.src_reg_b <= rb;
    instr_ch.immediate <= imm;
    instr_ch.read_byte <= rbyte;
    instr_ch.io_ok     <= ok;
    do @(posedge clk_i); while (!instr_ch.ready);
    words_sent++;
  endtask

  // Sends an instruction whose unused fields carry random noise.
  task automatic send_op(input logic [CmdW-1:0] cmd, input logic [RegIdxW-1:0] rd,
                         input logic [RegIdxW-1:0] ra, input logic [RegIdxW-1:0] rb,
                         input logic [ImmW-1:0] imm);
    send_instruction(cmd, rd, ra, rb, imm, ByteW'($urandom), 1'($urandom));
  endtask

  // Short well-formed program fragments with random content, mixed with raw noise.
  task automatic send_random_fragment();
    logic [RegIdxW-1:0] r1;
    logic [RegIdxW-1:0] r2;
    logic [ImmW-1:0]    imm;
    logic [CmdW-1:0]    cmd;
    r1 = any_reg();
    r2 = any_reg();
    case ($urandom_range(0, 9))
      0, 1: begin
        // Build a full-width value from two halves, then mix it with another register.
        send_op(CMD_SET, r1, any_reg(), any_reg(), ImmW'($urandom));
        send_op(CMD_SHL, r1, r1, any_reg(), 16);
        send_op(CMD_ORI, r1, r1, any_reg(), ImmW'($urandom));
        send_op(CmdW'($urandom_range(CMD_ADD, CMD_XOR)), any_reg(), r1, r2,
                ImmW'($urandom_range(0, 40)));
      end
      2, 3: begin
        // Store a byte through an address register and read it back.
        send_op(CMD_SET, r1, any_reg(), any_reg(), ImmW'($urandom));
        if ($urandom_range(0, 1)) begin
          send_op(CMD_ST, any_reg(), r1, any_reg(), ImmW'($urandom));
        end else begin
          send_op(CMD_STR, r2, r1, any_reg(), ImmW'($urandom));
        end
        if ($urandom_range(0, 1)) begin
          send_op(CMD_LDR, any_reg(), r1, any_reg(), ImmW'($urandom));
        end else begin
          send_op(CMD_LD, any_reg(), r1, any_reg(), ImmW'($urandom));
        end
      end
      4: begin
        // Conditional jumps on a register that is often zero.
        if ($urandom_range(0, 1)) begin
          send_op(CMD_SET, r1, any_reg(), any_reg(), ImmW'($urandom_range(0, 1)));
        end
        send_op(CmdW'($urandom_range(CMD_JMP, CMD_HLT)), r1, any_reg(),
                any_reg(), ImmW'($urandom));
      end
      5: begin
        // Read a character into a register and send it back out.
        send_instruction(CMD_READ, r1, r2, any_reg(), ImmW'($urandom), ByteW'($urandom),
                         1'($urandom));
        send_op(CMD_WRITE, r1, any_reg(), any_reg(), ImmW'($urandom));
      end
      default: begin
        // A single instruction with every field random, unused codes included.
        cmd = CmdW'($urandom);
        imm = ImmW'($urandom);
        if ((cmd == CMD_SHL || cmd == CMD_SHR) && $urandom_range(0, 3) != 0) begin
          imm = ImmW'($urandom_range(0, 40));
        end
        send_instruction(cmd, any_reg(), any_reg(), any_reg(), imm, ByteW'($urandom),
                         1'($urandom));
      end
    endcase
  endtask

  // Result side: a random stall before each word is taken.
  initial begin : result_sink
    int stall;
    result_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
    end
  end

  // Reset, directed instructions, random fragments, drain and verdict.
  initial begin : stimulus
    rst_ni             = 1'b0;
    words_sent         = 0;
    steady_flow        = 1'b0;
    instr_ch.valid     = 1'b0;
    instr_ch.command   = CMD_HLT;
    instr_ch.dest_reg  = '0;
    instr_ch.src_reg_a = '0;
    instr_ch.src_reg_b = '0;
    instr_ch.immediate = '0;
    instr_ch.read_byte = '0;
    instr_ch.io_ok     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes, every operation but ORI and the corner cases.
    send_instruction(CMD_SET, 1, 0, 0, 16'hFFFF, 8'h00, 1'b0);
    send_instruction(CMD_SHL, 2, 1, 0, 16, 8'h00, 1'b0);
    send_instruction(CMD_OR, 3, 2, 1, 0, 8'h00, 1'b0);
    send_instruction(CMD_ADDI, 4, 3, 0, 1, 8'h00, 1'b0);
    send_instruction(CMD_SUBI, 5, 4, 0, 1, 8'h00, 1'b0);
    send_instruction(CMD_ADD, 6, 3, 3, 0, 8'h00, 1'b0);
    send_instruction(CMD_SUB, 7, 4, 3, 0, 8'h00, 1'b0);
    send_instruction(CMD_SHR, 8, 3, 0, 31, 8'h00, 1'b0);
    send_instruction(CMD_SHL, 9, 3, 0, ImmW'(WordWidth), 8'h00, 1'b0);
    send_instruction(CMD_SHR, 10, 3, 0, 16'hFFFF, 8'h00, 1'b0);
    send_instruction(CMD_ANDI, 11, 3, 0, 16'h5A5A, 8'h00, 1'b0);
    send_instruction(CMD_XORI, 12, 3, 0, 16'hFFFF, 8'h00, 1'b0);
    send_instruction(CMD_AND, 13, 3, 12, 0, 8'h00, 1'b0);
    send_instruction(CMD_XOR, 14, 12, 3, 0, 8'h00, 1'b0);
    send_instruction(CMD_ST, 0, 1, 0, 16'hFFAB, 8'h00, 1'b0);
    send_instruction(CMD_STR, 3, 8, 0, 0, 8'h00, 1'b0);
    send_instruction(CMD_LDR, 15, 1, 0, 0, 8'h00, 1'b0);
    send_instruction(CMD_LD, 0, 8, 0, 16'hFFF0, 8'h00, 1'b0);
    // A read whose byte and status land in the same register, then a failed read.
    send_instruction(CMD_READ, 2, 2, 0, 0, 8'hC3, 1'b1);
    send_instruction(CMD_READ, 4, 5, 0, 0, 8'hFF, 1'b0);
    send_instruction(CMD_WRITE, 3, 6, 0, 0, 8'h00, 1'b1);
    send_instruction(CMD_JMP, 0, 0, 0, 16'hFFFF, 8'h00, 1'b0);
    send_instruction(CMD_JZ, 9, 0, 0, 16'h8001, 8'h00, 1'b0);
    send_instruction(CMD_JNZ, 9, 0, 0, 16'h8001, 8'h00, 1'b0);
    send_instruction(CMD_JNZ, 3, 0, 0, 16'h1234, 8'h00, 1'b0);
    send_instruction(CMD_HLT, 15, 15, 15, 16'hFFFF, 8'hFF, 1'b1);
    send_instruction(CmdUnusedLo, 1, 2, 3, 16'h0001, 8'h01, 1'b1);
    send_instruction(CmdUnusedHi, 15, 15, 15, 16'hFFFF, 8'hFF, 1'b1);

    // Random program fragments.
    while (words_sent < 28 + RandomWords) begin
      send_random_fragment();
    end
    instr_ch.valid <= 1'b0;

    // Wait for every outstanding word, then let the pipeline drain to catch anything stray.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
